// ===== design/trinomial_tree_option_pricer_assert.svh =====
// Assertion macros shared by the pricer's checks.
// Each macro expects clk and rst to be visible where it is used.
`ifndef TRINOMIAL_TREE_OPTION_PRICER_ASSERT_SVH
`define TRINOMIAL_TREE_OPTION_PRICER_ASSERT_SVH

// Same-cycle implication.
`define TTOP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TTOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ttop_pkg.sv =====
`timescale 1ns / 1ps
package ttop_pkg;

  // Option kinds.
  localparam logic OP_CALL = 1'b0;
  localparam logic OP_PUT  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_STEP_COUNT = 3'd0;
  localparam logic [2:0] REG_UP_FACTOR  = 3'd1;
  localparam logic [2:0] REG_DOWN_FACTOR = 3'd2;
  localparam logic [2:0] REG_PROB_UP    = 3'd3;
  localparam logic [2:0] REG_PROB_MID   = 3'd4;
  localparam logic [2:0] REG_PROB_DOWN  = 3'd5;
  localparam logic [2:0] REG_DISCOUNT   = 3'd6;

  typedef struct packed {
    logic        op;
    logic [31:0] future_price;
    logic [31:0] strike_price;
  } item_t;

  typedef struct packed {
    logic [31:0] option_value;
    logic        saturated;
  } result_t;

  // Branch weights broadcast to every lattice cell.
  typedef struct packed {
    logic [16:0] pu;
    logic [16:0] pm;
    logic [16:0] pd;
  } coef_t;

  // Backward-step controls for the cells.
  typedef struct packed {
    logic mul;
    logic acc;
  } cell_ctrl_t;

  // Controls for a terminal price lane.
  typedef struct packed {
    logic init;
    logic mul;
    logic upd;
  } lane_ctrl_t;

  // Payoff of a call or a put at one terminal price.
  function automatic logic [31:0] payoff(logic is_put, logic [31:0] price,
                                         logic [31:0] strike);
    logic [31:0] r;
    r = '0;
    if (is_put == OP_PUT) begin
      if (strike > price) r = strike - price;
    end else begin
      if (price > strike) r = price - strike;
    end
    return r;
  endfunction

endpackage

// ===== design/trinomial_tree_option_pricer.sv =====
`timescale 1ns / 1ps
// Trinomial lattice pricer for European options on a future.
// Software writes step count, up/down factors, branch probabilities and the
// discount through the configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high, unknown indexes are dropped.
// An option transfers in when start is high and busy is low. Its value
// appears on result for one cycle with done high; the receiver cannot stall.
// After the start transfer the two terminal price lanes fill the lattice
// (a multiply, then an update, per level), the backward steps run in the row
// of 2*MAX_STEPS+1 lattice cells (products, then sum), then come the discount
// multiply and the result register; a zero step count goes straight to the
// discount multiply. busy drops in the cycle done is shown, so the next option
// may start then. One option is in flight at a time.
// Reset restores the register defaults and returns the sequencer to idle;
// the node values need no clearing since every node is written before use.
module trinomial_tree_option_pricer #(
  parameter int MAX_STEPS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ttop_pkg::item_t  item,
  output logic             done,
  output ttop_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import ttop_pkg::*;

  localparam int NODES = 2 * MAX_STEPS + 1;
  localparam int IW    = $clog2(NODES);
  localparam int NW    = $clog2(MAX_STEPS + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FILL_MUL = 3'd1;
  localparam logic [2:0] S_FILL_WR  = 3'd2;
  localparam logic [2:0] S_BACK_MUL = 3'd3;
  localparam logic [2:0] S_BACK_ACC = 3'd4;
  localparam logic [2:0] S_DISC_MUL = 3'd5;
  localparam logic [2:0] S_DISC_OUT = 3'd6;

  logic [8:0]  step_count;
  logic [31:0] up_factor;
  logic [31:0] down_factor;
  coef_t       coef;
  logic [16:0] discount_factor;

  logic [2:0]    state;
  logic [NW-1:0] n_reg;
  logic [NW-1:0] n_cur;
  logic [NW-1:0] cnt;
  logic          is_put;
  logic [31:0]   strike;
  logic          sat_flag;
  logic [48:0]   dprod;

  logic       accept;
  lane_ctrl_t lane_ctrl;
  cell_ctrl_t cell_ctrl;
  logic [31:0] up_payoff;
  logic [31:0] dn_payoff;
  logic        up_sat;
  logic        dn_sat;

  logic          wa_valid;
  logic [IW-1:0] wa_idx;
  logic [31:0]   wa_data;
  logic          wb_valid;
  logic [IW-1:0] wb_idx;

  logic [31:0] vals [NODES];

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count      <= 9'd1;
      up_factor       <= 32'h4000_0000;
      down_factor     <= 32'h4000_0000;
      coef.pu         <= 17'd0;
      coef.pm         <= 17'd65536;
      coef.pd         <= 17'd0;
      discount_factor <= 17'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_COUNT:  step_count      <= cfg_data[8:0];
        REG_UP_FACTOR:   up_factor       <= cfg_data;
        REG_DOWN_FACTOR: down_factor     <= cfg_data;
        REG_PROB_UP:     coef.pu         <= cfg_data[16:0];
        REG_PROB_MID:    coef.pm         <= cfg_data[16:0];
        REG_PROB_DOWN:   coef.pd         <= cfg_data[16:0];
        REG_DISCOUNT:    discount_factor <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Step count clamped to the lattice size.
  always_comb begin
    if (32'(step_count) > MAX_STEPS) begin
      n_cur = NW'(MAX_STEPS);
    end else begin
      n_cur = NW'(step_count);
    end
  end

  // Lane and cell controls follow the sequencer state.
  always_comb begin
    lane_ctrl.init = accept;
    lane_ctrl.mul  = (state == S_FILL_MUL);
    lane_ctrl.upd  = (state == S_FILL_WR);
    cell_ctrl.mul  = (state == S_BACK_MUL);
    cell_ctrl.acc  = (state == S_BACK_ACC);
  end

  // Terminal write buses: the middle node at start, then one node above
  // and one below the middle per level.
  always_comb begin
    wa_valid = accept || (state == S_FILL_WR);
    wb_valid = (state == S_FILL_WR);
    wb_idx   = IW'(n_reg) - IW'(cnt) - IW'(1);
    if (accept) begin
      wa_idx  = IW'(n_cur);
      wa_data = payoff(item.op, item.future_price, item.strike_price);
    end else begin
      wa_idx  = IW'(n_reg) + IW'(cnt) + IW'(1);
      wa_data = up_payoff;
    end
  end

  ttop_lane u_lane_up (
    .clk        (clk),
    .ctrl       (lane_ctrl),
    .start_price(item.future_price),
    .factor     (up_factor),
    .is_put     (is_put),
    .strike     (strike),
    .payoff_out (up_payoff),
    .sat_hit    (up_sat)
  );

  ttop_lane u_lane_dn (
    .clk        (clk),
    .ctrl       (lane_ctrl),
    .start_price(item.future_price),
    .factor     (down_factor),
    .is_put     (is_put),
    .strike     (strike),
    .payoff_out (dn_payoff),
    .sat_hit    (dn_sat)
  );

  // Row of lattice cells; each reads its two upper neighbors where they exist.
  for (genvar k = 0; k < NODES; k++) begin : g_cell
    logic        hit_a;
    logic        hit_b;
    logic [31:0] v_mid;
    logic [31:0] v_up;

    assign hit_a = wa_valid && (wa_idx == IW'(k));
    assign hit_b = wb_valid && (wb_idx == IW'(k));

    if (k + 2 < NODES) begin : g_full
      assign v_mid = vals[k + 1];
      assign v_up  = vals[k + 2];
    end else if (k + 1 < NODES) begin : g_edge
      assign v_mid = vals[k + 1];
      assign v_up  = '0;
    end else begin : g_top
      assign v_mid = '0;
      assign v_up  = '0;
    end

    ttop_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .coef     (coef),
      .load     (hit_a || hit_b),
      .load_data(hit_a ? wa_data : dn_payoff),
      .value_mid(v_mid),
      .value_up (v_up),
      .value    (vals[k])
    );
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n_reg    <= n_cur;
            cnt      <= '0;
            is_put   <= item.op;
            strike   <= item.strike_price;
            sat_flag <= 1'b0;
            state    <= (n_cur == '0) ? S_DISC_MUL : S_FILL_MUL;
          end
        end
        S_FILL_MUL: begin
          state <= S_FILL_WR;
        end
        S_FILL_WR: begin
          sat_flag <= sat_flag || up_sat || dn_sat;
          if (cnt == n_reg - NW'(1)) begin
            cnt   <= '0;
            state <= S_BACK_MUL;
          end else begin
            cnt   <= cnt + NW'(1);
            state <= S_FILL_MUL;
          end
        end
        S_BACK_MUL: begin
          state <= S_BACK_ACC;
        end
        S_BACK_ACC: begin
          if (cnt == n_reg - NW'(1)) begin
            state <= S_DISC_MUL;
          end else begin
            cnt   <= cnt + NW'(1);
            state <= S_BACK_MUL;
          end
        end
        S_DISC_MUL: begin
          dprod <= 49'(vals[0]) * 49'(discount_factor);
          state <= S_DISC_OUT;
        end
        S_DISC_OUT: begin
          result.option_value <= (|dprod[48:48]) ? 32'hFFFF_FFFF : dprod[47:16];
          result.saturated    <= sat_flag;
          done                <= 1'b1;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "trinomial_tree_option_pricer_assert.svh"

  `TTOP_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
  `TTOP_ASSERT_NEXT(a_start_busy, start && !busy, busy, "start transfer did not raise busy")
  `TTOP_ASSERT_NEXT(a_done_once, done, !done, "result strobe longer than one cycle")

endmodule

// ===== design/ttop_lane.sv =====
`timescale 1ns / 1ps
module ttop_lane (
  input  logic                clk,
  input  ttop_pkg::lane_ctrl_t ctrl,
  input  logic [31:0]         start_price,
  input  logic [31:0]         factor,
  input  logic                is_put,
  input  logic [31:0]         strike,
  output logic [31:0]         payoff_out,
  output logic                sat_hit
);
  import ttop_pkg::*;

  logic [31:0] price;
  logic [63:0] prod;
  logic [33:0] scaled;
  logic [31:0] price_next;

  // Truncate the Q2.30 product and saturate at the top of the word.
  always_comb begin
    scaled     = prod[63:30];
    sat_hit    = |scaled[33:32];
    price_next = sat_hit ? 32'hFFFF_FFFF : scaled[31:0];
    payoff_out = payoff(is_put, price_next, strike);
  end

  // For each lattice level the product is registered first, then the price is updated.
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      price <= start_price;
    end else if (ctrl.upd) begin
      price <= price_next;
    end
    if (ctrl.mul) begin
      prod <= 64'(price) * 64'(factor);
    end
  end

endmodule

// ===== design/ttop_cell.sv =====
`timescale 1ns / 1ps
module ttop_cell (
  input  logic                 clk,
  input  ttop_pkg::cell_ctrl_t ctrl,
  input  ttop_pkg::coef_t      coef,
  input  logic                 load,
  input  logic [31:0]          load_data,
  input  logic [31:0]          value_mid,
  input  logic [31:0]          value_up,
  output logic [31:0]          value
);
  import ttop_pkg::*;

  logic [48:0] prod_up;
  logic [48:0] prod_mid;
  logic [48:0] prod_dn;
  logic [50:0] sum;
  logic [31:0] value_next;

  // Weighted sum of the three children, truncated and saturated.
  always_comb begin
    sum = 51'(prod_up) + 51'(prod_mid) + 51'(prod_dn);
    value_next = (|sum[50:48]) ? 32'hFFFF_FFFF : sum[47:16];
  end

  // Products are registered first, then summed into the node in the next cycle.
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_up  <= 49'(coef.pu) * 49'(value_up);
      prod_mid <= 49'(coef.pm) * 49'(value_mid);
      prod_dn  <= 49'(coef.pd) * 49'(value);
    end
    if (load) begin
      value <= load_data;
    end else if (ctrl.acc) begin
      value <= value_next;
    end
  end

endmodule

// ===== bench/trinomial_tree_option_pricer_tb.sv =====
`timescale 1ns / 1ps
module trinomial_tree_option_pricer_tb;
  import ttop_pkg::*;

  localparam int MAX_N = 256;
  localparam int LIMIT = 3000000;

  // Index past the end of the register list; writes to it are dropped.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Scoreboard of predicted option values, oldest first.
  class value_board;
    result_t pending[$];
    int errors;
    int shown;

    function new();
      errors = 0;
      shown = 0;
    endfunction

    function void note(result_t r);
      pending.push_back(r);
    endfunction

    function void check(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result value=%h sat=%b", got.option_value, got.saturated);
        end
        return;
      end
      want = pending.pop_front();
      if (got.option_value !== want.option_value || got.saturated !== want.saturated) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected value=%h sat=%b, actual value=%h sat=%b",
                   want.option_value, want.saturated, got.option_value, got.saturated);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Model copy of the registers.
  logic [8:0] m_steps;
  logic [31:0] m_up, m_down;
  logic [16:0] m_pu, m_pm, m_pd, m_disc;
  logic [31:0] nodes [0:2*MAX_N];

  value_board board;
  int cycles = 0;

  trinomial_tree_option_pricer DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Check every strobed result at the edge that ends its cycle.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) board.check(result);
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] clip(logic [63:0] v);
    return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
  endfunction

  function automatic logic [31:0] gain(logic is_put, logic [31:0] p, logic [31:0] k);
    if (is_put) return (k > p) ? k - p : 32'd0;
    return (p > k) ? p - k : 32'd0;
  endfunction

  // Lattice value of one option under the current registers.
  function automatic result_t price_option(item_t it);
    result_t r;
    int n, last, i, k, j;
    logic [31:0] p;
    logic [63:0] prod, acc;
    logic sat;
    n = (m_steps > MAX_N) ? MAX_N : m_steps;
    last = 2 * n;
    sat = 1'b0;
    nodes[n] = gain(it.op, it.future_price, it.strike_price);
    p = it.future_price;
    for (j = n + 1; j <= last; j++) begin
      prod = ({32'd0, p} * {32'd0, m_up}) >> 30;
      if (prod > 64'hFFFFFFFF) sat = 1'b1;
      p = clip(prod);
      nodes[j] = gain(it.op, p, it.strike_price);
    end
    p = it.future_price;
    for (j = n; j > 0; j--) begin
      prod = ({32'd0, p} * {32'd0, m_down}) >> 30;
      if (prod > 64'hFFFFFFFF) sat = 1'b1;
      p = clip(prod);
      nodes[j-1] = gain(it.op, p, it.strike_price);
    end
    for (i = 0; i < n; i++) begin
      for (k = 0; k < last - 2*i - 1; k++) begin
        acc = 64'(m_pu) * 64'(nodes[k+2]) + 64'(m_pm) * 64'(nodes[k+1])
              + 64'(m_pd) * 64'(nodes[k]);
        nodes[k] = clip(acc >> 16);
      end
    end
    r.option_value = clip((64'(nodes[0]) * 64'(m_disc)) >> 16);
    r.saturated = sat;
    return r;
  endfunction

  // One register transfer; the task ends with cfg_valid low so drives never overlap.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STEP_COUNT:  m_steps = val[8:0];
      REG_UP_FACTOR:   m_up = val;
      REG_DOWN_FACTOR: m_down = val;
      REG_PROB_UP:     m_pu = val[16:0];
      REG_PROB_MID:    m_pm = val[16:0];
      REG_PROB_DOWN:   m_pd = val[16:0];
      REG_DISCOUNT:    m_disc = val[16:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until every predicted result has arrived.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_setting(logic [8:0] n, logic [31:0] u, logic [31:0] d,
                              logic [16:0] pu, logic [16:0] pm, logic [16:0] pd,
                              logic [16:0] disc);
    write_reg(REG_STEP_COUNT, {23'd0, n});
    write_reg(REG_UP_FACTOR, u);
    write_reg(REG_DOWN_FACTOR, d);
    write_reg(REG_PROB_UP, {15'd0, pu});
    write_reg(REG_PROB_MID, {15'd0, pm});
    write_reg(REG_PROB_DOWN, {15'd0, pd});
    write_reg(REG_DISCOUNT, {15'd0, disc});
  endtask

  // Hold start until the transfer happens, then note the prediction.
  // The block is busy right after a transfer, so the trailing edge costs nothing.
  task automatic send_option(item_t it);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note(price_option(it));
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.op = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: it.future_price = $urandom();
      1: it.future_price = $urandom_range(0, 32'h00FFFFFF);
      2: it.future_price = 32'hFFFFFFFF - $urandom_range(0, 255);
      default: it.future_price = $urandom_range(32'h00100000, 32'h01000000);
    endcase
    if ($urandom_range(0, 3) == 0) it.strike_price = $urandom();
    else it.strike_price = it.future_price + $urandom_range(0, 32'h000FFFFF)
                           - 32'h00080000;
    return it;
  endfunction

  // Burst of random options with random gaps.
  task automatic random_burst(int count);
    int left, b;
    left = count;
    while (left > 0) begin
      b = $urandom_range(1, 8);
      while (b > 0 && left > 0) begin
        send_option(rand_item());
        b--;
        left--;
      end
      repeat ($urandom_range(0, 5)) @(posedge clk);
    end
  endtask

  initial begin
    item_t it;
    int ph;
    logic [16:0] a, b2, c;
    board = new();
    m_steps = 9'd1; m_up = 32'h40000000; m_down = 32'h40000000;
    m_pu = 17'd0; m_pm = 17'd65536; m_pd = 17'd0; m_disc = 17'd65536;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed options under the reset registers.
    it = '{OP_CALL, 32'h00010000, 32'h00008000}; send_option(it);
    it = '{OP_PUT, 32'h00008000, 32'h00010000}; send_option(it);
    it = '{OP_CALL, 32'hFFFFFFFF, 32'h00000000}; send_option(it);
    it = '{OP_PUT, 32'h00000000, 32'hFFFFFFFF}; send_option(it);
    drain();

    // Zero steps, ignored index, too many steps, saturating setups.
    write_reg(REG_STEP_COUNT, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    it = '{OP_CALL, 32'h00020000, 32'h00010000}; send_option(it);
    it = '{OP_PUT, 32'h00020000, 32'h00030000}; send_option(it);
    drain();
    load_setting(9'd511, 32'h40400000, 32'h3FC00000, 17'd21845, 17'd21846, 17'd21845,
                 17'd65000);
    it = '{OP_CALL, 32'h00640000, 32'h00600000}; send_option(it);
    it = '{OP_PUT, 32'hFFFFFFFF, 32'h00010000}; send_option(it);
    drain();
    load_setting(9'd4, 32'hFFFFFFFF, 32'hFFFFFFFF, 17'd65536, 17'd65536, 17'd65536,
                 17'd65536);
    it = '{OP_CALL, 32'h80000000, 32'h00000000}; send_option(it);
    it = '{OP_PUT, 32'h00001000, 32'hFFFFFFFF}; send_option(it);
    it = '{OP_CALL, 32'h00000000, 32'h00000000}; send_option(it);
    drain();
    load_setting(9'd256, 32'd0, 32'd0, 17'd0, 17'd0, 17'd0, 17'd0);
    it = '{OP_CALL, 32'h12345678, 32'h00000001}; send_option(it);
    drain();

    // Random phases; mostly small lattices, a few large ones up to full size.
    for (ph = 0; ph < 12; ph++) begin
      a = $urandom_range(0, 65536);
      b2 = $urandom_range(0, 65536 - a);
      c = 17'd65536 - a - b2;
      if (ph == 5) begin a = 17'h1FFFF; b2 = 17'h1FFFF; c = 17'h1FFFF; end
      load_setting((ph % 6 == 5) ? 9'($urandom_range(200, 511)) : 9'($urandom_range(0, 12)),
                   $urandom_range(32'h40000000, 32'h48000000),
                   $urandom_range(32'h38000000, 32'h40000000),
                   a, b2, c, (ph == 7) ? 17'h1FFFF : 17'($urandom_range(50000, 65536)));
      random_burst((ph % 6 == 5) ? 10 : 54);
      drain();
    end

    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== trinomial_tree_option_pricer.f =====
+incdir+design
design/ttop_pkg.sv
design/ttop_lane.sv
design/ttop_cell.sv
design/trinomial_tree_option_pricer.sv
bench/trinomial_tree_option_pricer_tb.sv
